>>> src/assert_macros.svh
// assertion macros for the rtl files, used by gspc_dp
// no dependencies; SYNTH builds get empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define GSPC_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gspc assertion failed");
`define GSPC_ASSERT_NR(name, clk, prop) \
    name: assert property (@(posedge clk) prop) else $error("gspc assertion failed");
`else
`define GSPC_ASSERT(name, clk, rst_n, prop)
`define GSPC_ASSERT_NR(name, clk, prop)
`endif
`endif

>>> src/gspc_pkg.sv
// shared types and constants of the grid path cost unit
// used by the controller, the datapath and the top level
package gspc_pkg;
    localparam int DIST_W = 17;
    localparam logic [DIST_W-1:0] DIST_INF = 17'h1FFFF;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_ONE  = 2'd1;
    localparam logic [1:0] MODE_PAIR = 2'd2;

    localparam logic [1:0] CFG_ROWS   = 2'd0;
    localparam logic [1:0] CFG_COLS   = 2'd1;
    localparam logic [1:0] CFG_BUDGET = 2'd2;

    typedef struct packed {
        logic capture;
        logic clr_init;
        logic clr_step;
        logic seed;
        logic scan_reset;
        logic scan_issue;
        logic settle;
        logic nb_init;
        logic nb_rd;
        logic nb_wr;
        logic nb_next;
        logic res_inf;
        logic res_best;
        logic next_search;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_query;
        logic out_of_grid;
        logic clr_last;
        logic scan_last;
        logic best_inf;
        logic at_end;
        logic nb_valid;
        logic nb_last;
        logic more_search;
        logic out_free;
    } t_status;
endpackage

>>> src/gspc_ram.sv
// generic simple dual-port ram, one write and one registered read
// no dependencies
module gspc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/gspc_ctrl.sv
// sequencer of the grid path cost unit: load, clear, scan, relax, report
// depends on gspc_pkg
module gspc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  gspc_pkg::t_status i_st,
    output gspc_pkg::t_cmd    o_cmd
);
    import gspc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_CLEAR, S_SEED, S_SCAN, S_TAIL,
        S_DECIDE, S_NB_RD, S_NB_WR, S_FIN
    } t_state;

    t_state r_state, n_state;
    t_cmd   cmd;

    always_comb begin
        cmd = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                cmd.capture = i_in_valid;
                if (i_in_valid && i_st.is_query) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                if (i_st.out_of_grid) begin
                    cmd.res_inf = 1'b1;
                    n_state = S_FIN;
                end else begin
                    cmd.clr_init = 1'b1;
                    n_state = S_CLEAR;
                end
            end
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (i_st.clr_last) begin
                    n_state = S_SEED;
                end
            end
            S_SEED: begin
                cmd.seed = 1'b1;
                cmd.scan_reset = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                cmd.scan_issue = 1'b1;
                if (i_st.scan_last) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_st.best_inf) begin
                    cmd.res_inf = 1'b1;
                    n_state = S_FIN;
                end else begin
                    cmd.settle = 1'b1;
                    if (i_st.at_end) begin
                        cmd.res_best = 1'b1;
                        n_state = S_FIN;
                    end else begin
                        cmd.nb_init = 1'b1;
                        n_state = S_NB_RD;
                    end
                end
            end
            S_NB_RD: begin
                if (i_st.nb_valid) begin
                    cmd.nb_rd = 1'b1;
                    n_state = S_NB_WR;
                end else begin
                    cmd.nb_next = 1'b1;
                    if (i_st.nb_last) begin
                        cmd.scan_reset = 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end
            S_NB_WR: begin
                cmd.nb_wr = 1'b1;
                cmd.nb_next = 1'b1;
                if (i_st.nb_last) begin
                    cmd.scan_reset = 1'b1;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_NB_RD;
                end
            end
            S_FIN: begin
                if (i_st.more_search) begin
                    cmd.next_search = 1'b1;
                    n_state = S_START;
                end else if (i_st.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_stall = (r_state != S_IDLE);
endmodule

>>> src/gspc_dp.sv
// datapath: grid maps, distance store, scan for least distance, neighbour relax
// depends on gspc_pkg, gspc_ram and assert_macros.svh
`include "assert_macros.svh"
module gspc_dp #(
    parameter int GRID_DIM  = 32,
    parameter int COST_BITS = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [15:0]    i_cfg_data,
    input  logic [1:0]     i_mode,
    input  logic [4:0]     i_cell_row,
    input  logic [4:0]     i_cell_col,
    input  logic           i_cell_is_blocked,
    input  logic [7:0]     i_cell_cost,
    input  logic [4:0]     i_start_row,
    input  logic [4:0]     i_start_col,
    input  logic [4:0]     i_alt_start_row,
    input  logic [4:0]     i_alt_start_col,
    input  logic [4:0]     i_end_row,
    input  logic [4:0]     i_end_col,
    input  logic           i_out_stall,
    output logic           o_out_valid,
    output logic           o_found,
    output logic [15:0]    o_path_cost,
    output logic           o_from_second_start,
    input  gspc_pkg::t_cmd i_cmd,
    output gspc_pkg::t_status o_st
);
    import gspc_pkg::*;

    localparam int CELLS = GRID_DIM * GRID_DIM;
    localparam int IW = $clog2(CELLS);
    localparam int CW = ($clog2(GRID_DIM + 1) > 6) ? $clog2(GRID_DIM + 1) : 6;

    function automatic logic [IW-1:0] cell_idx(input logic [CW-1:0] r, input logic [CW-1:0] c);
        cell_idx = IW'(int'(r) * GRID_DIM + int'(c));
    endfunction

    function automatic logic [CW-1:0] clamp_dim(input logic [5:0] v);
        if (v == 6'd0) begin
            clamp_dim = CW'(1);
        end else if (int'(v) > GRID_DIM) begin
            clamp_dim = CW'(GRID_DIM);
        end else begin
            clamp_dim = CW'(v);
        end
    endfunction

    // configuration
    logic [5:0]  r_rows_raw, r_cols_raw;
    logic [15:0] r_budget;
    logic [CW-1:0] rows, cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_raw <= 6'd32;
            r_cols_raw <= 6'd32;
            r_budget   <= 16'hFFFF;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROWS:   r_rows_raw <= i_cfg_data[5:0];
                CFG_COLS:   r_cols_raw <= i_cfg_data[5:0];
                CFG_BUDGET: r_budget   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign rows = clamp_dim(r_rows_raw);
    assign cols = clamp_dim(r_cols_raw);

    // captured query word
    logic [1:0]    r_mode;
    logic [CW-1:0] r_sr, r_sc, r_ar, r_ac, r_er, r_ec;
    logic          r_second;
    logic [DIST_W-1:0] r_c1, r_res;
    logic [DIST_W-1:0] r_best;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_sr   <= CW'(i_start_row);
            r_sc   <= CW'(i_start_col);
            r_ar   <= CW'(i_alt_start_row);
            r_ac   <= CW'(i_alt_start_col);
            r_er   <= CW'(i_end_row);
            r_ec   <= CW'(i_end_col);
        end
        if (i_cmd.res_inf) begin
            r_res <= DIST_INF;
        end else if (i_cmd.res_best) begin
            r_res <= r_best;
        end
        if (i_cmd.next_search) begin
            r_c1 <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second <= 1'b0;
        end else if (i_cmd.capture) begin
            r_second <= 1'b0;
        end else if (i_cmd.next_search) begin
            r_second <= 1'b1;
        end
    end

    logic [CW-1:0] cur_sr, cur_sc;
    assign cur_sr = r_second ? r_ar : r_sr;
    assign cur_sc = r_second ? r_ac : r_sc;

    // clear counter
    logic [IW-1:0] r_clr;
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_init) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + IW'(1);
        end
    end

    // scan over the cells in use, read data arrives in the cycle after its address
    logic [CW-1:0] r_scr, r_scc, r_pr, r_pc, r_br, r_bc;
    logic          r_pv;
    logic [DIST_W:0]   dist_rdata;
    logic              scan_last;

    assign scan_last = (r_scr == rows - CW'(1)) && (r_scc == cols - CW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_cmd.scan_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_reset) begin
            r_scr  <= '0;
            r_scc  <= '0;
            r_best <= DIST_INF;
        end else begin
            if (i_cmd.scan_issue) begin
                r_pr <= r_scr;
                r_pc <= r_scc;
                if (r_scc == cols - CW'(1)) begin
                    r_scc <= '0;
                    r_scr <= r_scr + CW'(1);
                end else begin
                    r_scc <= r_scc + CW'(1);
                end
            end
            if (r_pv && !dist_rdata[DIST_W] && dist_rdata[DIST_W-1:0] < r_best) begin
                r_best <= dist_rdata[DIST_W-1:0];
                r_br   <= r_pr;
                r_bc   <= r_pc;
            end
        end
    end

    // neighbour walk: up, down, left, right
    logic [1:0]    r_nk;
    logic [CW-1:0] nr, nc;
    logic          nb_valid;
    logic [IW-1:0] nidx, r_nidx;

    always_comb begin
        nr = r_br;
        nc = r_bc;
        nb_valid = 1'b0;
        case (r_nk)
            2'd0: begin
                nr = r_br - CW'(1);
                nb_valid = (r_br != '0);
            end
            2'd1: begin
                nr = r_br + CW'(1);
                nb_valid = (nr < rows);
            end
            2'd2: begin
                nc = r_bc - CW'(1);
                nb_valid = (r_bc != '0);
            end
            default: begin
                nc = r_bc + CW'(1);
                nb_valid = (nc < cols);
            end
        endcase
    end

    assign nidx = cell_idx(nr, nc);

    always_ff @(posedge i_clk) begin
        if (i_cmd.nb_init) begin
            r_nk <= '0;
        end else if (i_cmd.nb_next) begin
            r_nk <= r_nk + 2'd1;
        end
        if (i_cmd.nb_rd) begin
            r_nidx <= nidx;
        end
    end

    // grid map
    logic                 cell_we;
    logic [IW-1:0]        cell_waddr;
    logic [COST_BITS:0]   cell_rdata;
    logic [DIST_W-1:0]    nd;

    assign cell_we = i_cmd.capture && (i_mode == MODE_LOAD)
                   && (int'(i_cell_row) < GRID_DIM) && (int'(i_cell_col) < GRID_DIM);
    assign cell_waddr = cell_idx(CW'(i_cell_row), CW'(i_cell_col));

    gspc_ram #(.WIDTH(COST_BITS + 1), .DEPTH(CELLS)) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (cell_we),
        .i_waddr (cell_waddr),
        .i_wdata ({i_cell_is_blocked, COST_BITS'(i_cell_cost)}),
        .i_raddr (nidx),
        .o_rdata (cell_rdata)
    );

    assign nd = r_best + DIST_W'(cell_rdata[COST_BITS-1:0]);

    // distance store, top bit is the settled flag
    logic              dist_we;
    logic [IW-1:0]     dist_waddr, dist_raddr;
    logic [DIST_W:0]   dist_wdata;

    always_comb begin
        dist_we    = 1'b0;
        dist_waddr = r_clr;
        dist_wdata = {1'b0, DIST_INF};
        if (i_cmd.clr_step) begin
            dist_we = 1'b1;
        end else if (i_cmd.seed) begin
            dist_we    = 1'b1;
            dist_waddr = cell_idx(cur_sr, cur_sc);
            dist_wdata = '0;
        end else if (i_cmd.settle) begin
            dist_we    = 1'b1;
            dist_waddr = cell_idx(r_br, r_bc);
            dist_wdata = {1'b1, r_best};
        end else if (i_cmd.nb_wr) begin
            dist_waddr = r_nidx;
            dist_wdata = {dist_rdata[DIST_W], nd};
            dist_we    = !cell_rdata[COST_BITS] && (nd < dist_rdata[DIST_W-1:0])
                       && (nd <= DIST_W'(r_budget));
        end
    end

    assign dist_raddr = i_cmd.nb_rd ? nidx : cell_idx(r_scr, r_scc);

    gspc_ram #(.WIDTH(DIST_W + 1), .DEPTH(CELLS)) u_dist_ram (
        .i_clk   (i_clk),
        .i_we    (dist_we),
        .i_waddr (dist_waddr),
        .i_wdata (dist_wdata),
        .i_raddr (dist_raddr),
        .o_rdata (dist_rdata)
    );

    // pick between the two starts, first one wins a tie
    logic [DIST_W-1:0] c1, c2, cfin;
    logic pick2;
    assign c1    = (r_mode == MODE_PAIR) ? r_c1 : r_res;
    assign c2    = (r_mode == MODE_PAIR) ? r_res : DIST_INF;
    assign pick2 = (c2 != DIST_INF) && ((c1 == DIST_INF) || (c2 < c1));
    assign cfin  = pick2 ? c2 : c1;

    // output word register
    logic        r_ov, r_ofound, r_osec;
    logic [15:0] r_ocost;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_ofound <= (cfin != DIST_INF);
            r_ocost  <= (cfin != DIST_INF) ? cfin[15:0] : 16'd0;
            r_osec   <= pick2;
        end
    end

    assign o_out_valid         = r_ov;
    assign o_found             = r_ofound;
    assign o_path_cost         = r_ocost;
    assign o_from_second_start = r_osec;

    // status
    always_comb begin
        o_st = '0;
        o_st.is_query    = (i_mode == MODE_ONE) || (i_mode == MODE_PAIR);
        o_st.out_of_grid = (cur_sr >= rows) || (cur_sc >= cols)
                         || (r_er >= rows) || (r_ec >= cols);
        o_st.clr_last    = (int'(r_clr) == CELLS - 1);
        o_st.scan_last   = scan_last;
        o_st.best_inf    = (r_best == DIST_INF);
        o_st.at_end      = (r_br == r_er) && (r_bc == r_ec);
        o_st.nb_valid    = nb_valid;
        o_st.nb_last     = (r_nk == 2'd3);
        o_st.more_search = (r_mode == MODE_PAIR) && !r_second;
        o_st.out_free    = !r_ov || !i_out_stall;
    end

    `GSPC_ASSERT(a_out_from_load, i_clk, i_rst_n, $rose(r_ov) |-> $past(i_cmd.out_load))
    `GSPC_ASSERT(a_miss_is_zero, i_clk, i_rst_n, (r_ov && !r_ofound) |-> (r_ocost == 16'd0 && !r_osec))
    `GSPC_ASSERT(a_second_found, i_clk, i_rst_n, (r_ov && r_osec) |-> r_ofound)
endmodule

>>> src/grid_shortest_path_cost_unit.sv
// grid least-cost path unit, top level
// depends on gspc_pkg, gspc_ctrl, gspc_dp (and gspc_ram inside it)
//
// input channel: i_in_valid / o_in_stall carries one word per item. mode 0
// loads one cell (blocked flag, entry cost) and does not stall; mode 1 and 2
// are queries that return one word on the output channel (o_out_valid /
// i_out_stall); mode 3 is dropped.
// a query runs one search per start. each search with its start and end inside
// the grid clears the distance store, all GRID_DIM*GRID_DIM cells (1024 by
// default), one cell a cycle, then repeats a scan over the rows*cols cells in
// use (one cell a cycle, set by the single read port of the distance ram), a
// tail and a decide state to pick the cell, and a relaxation of up to four
// neighbours, once per settled cell. a two-start query is two searches.
// the unit accepts no item while a query runs.
// the result word waits in an output register while the receiver stalls; a
// finished query holds until that register is free, and no item is taken
// until it has moved there.
// reset (synchronous, active low) empties the output and restores the grid
// size to 32x32 and the budget to 65535; cell contents are kept unknown.
module grid_shortest_path_cost_unit #(
    parameter int GRID_DIM  = 32,
    parameter int COST_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [4:0]  i_cell_row,
    input  logic [4:0]  i_cell_col,
    input  logic        i_cell_is_blocked,
    input  logic [7:0]  i_cell_cost,
    input  logic [4:0]  i_start_row,
    input  logic [4:0]  i_start_col,
    input  logic [4:0]  i_alt_start_row,
    input  logic [4:0]  i_alt_start_col,
    input  logic [4:0]  i_end_row,
    input  logic [4:0]  i_end_col,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_found,
    output logic [15:0] o_path_cost,
    output logic        o_from_second_start
);
    import gspc_pkg::*;

    t_cmd    cmd;
    t_status st;

    gspc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    gspc_dp #(.GRID_DIM(GRID_DIM), .COST_BITS(COST_BITS)) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_mode              (i_mode),
        .i_cell_row          (i_cell_row),
        .i_cell_col          (i_cell_col),
        .i_cell_is_blocked   (i_cell_is_blocked),
        .i_cell_cost         (i_cell_cost),
        .i_start_row         (i_start_row),
        .i_start_col         (i_start_col),
        .i_alt_start_row     (i_alt_start_row),
        .i_alt_start_col     (i_alt_start_col),
        .i_end_row           (i_end_row),
        .i_end_col           (i_end_col),
        .i_out_stall         (i_out_stall),
        .o_out_valid         (o_out_valid),
        .o_found             (o_found),
        .o_path_cost         (o_path_cost),
        .o_from_second_start (o_from_second_start),
        .i_cmd               (cmd),
        .o_st                (st)
    );
endmodule
